// ===== rtl/core/amhr_pkg.sv =====
// package for the aging measurement history ring
// holds ring geometry, period limits, command codes and sequencer states
// no dependencies
package amhr_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    localparam logic [7:0] PERIOD_MIN   = 8'd1;
    localparam logic [7:0] PERIOD_MAX   = 8'd240;
    localparam logic [7:0] PERIOD_RESET = 8'd1;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WALK_END,
        ST_ADD_WRITE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } t_state;

endpackage

// ===== rtl/core/aging_measurement_history_ring_top.sv =====
// aging measurement history ring: ring of temperature/humidity records with ages
// add: accepted in idle, then ST_WALK bumps the older records, then ST_WALK_END and ST_ADD_WRITE
//   the walk is set by the single age ram port pair, one read-modify-write per cycle
// read: ST_RD_ISSUE, then ST_RD_DATA loads the output register; clear and unused kinds finish in idle
// one item at a time; o_in_ready only in idle, result held in an output register
// reset (synchronous, active low) zeroes pointer and count, sets period to 1; no ram clear
module aging_measurement_history_ring_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic signed [15:0] i_temperature,
    input  logic signed [15:0] i_humidity,
    input  logic [7:0]  i_read_index,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [15:0] o_age,
    output logic signed [15:0] o_stored_temperature,
    output logic signed [15:0] o_stored_humidity,
    output logic [8:0]  o_record_count
);

    import amhr_pkg::*;

    // control state
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_wp, n_wp;          // write pointer
    logic [CNT_W-1:0]    r_count, n_count;    // records held
    logic [ADDR_W-1:0]   r_k, n_k;            // records back from newest
    logic [ADDR_W-1:0]   r_older, n_older;    // number of ages to bump
    logic                r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0]   r_wb_addr, n_wb_addr;
    logic [7:0]          r_period;
    logic                r_out_valid, n_out_valid;

    // payload registers
    logic [15:0]         r_temp, n_temp;
    logic [15:0]         r_hum, n_hum;
    logic                r_found, n_found;
    logic                r_o_found, n_o_found;
    logic [15:0]         r_o_age, n_o_age;
    logic [15:0]         r_o_temp, n_o_temp;
    logic [15:0]         r_o_hum, n_o_hum;
    logic [CNT_W-1:0]    r_o_count, n_o_count;

    // ram side
    logic [ADDR_W-1:0]   slot;
    logic                age_we;
    logic [ADDR_W-1:0]   age_wr_addr;
    logic [15:0]         age_wr_data;
    logic [15:0]         age_rd_data;
    logic                smp_we;
    logic [31:0]         smp_rd_data;
    logic                in_xfer;
    logic                out_free;
    logic [7:0]          period_clamped;

    // shared slot unit: newest slot minus r_k, wraps around the ring
    assign slot = r_wp - ADDR_W'(1) - r_k;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // age ram: pipelined read-modify-write during the walk, zero for the new record
    assign age_we      = r_wb_valid || (r_state == ST_ADD_WRITE);
    assign age_wr_addr = r_wb_valid ? r_wb_addr : r_wp;
    assign age_wr_data = r_wb_valid ? (age_rd_data + {8'd0, r_period}) : 16'd0;
    assign smp_we      = (r_state == ST_ADD_WRITE);

    amhr_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_age_ram (
        .i_clk     (i_clk),
        .i_wr_en   (age_we),
        .i_wr_addr (age_wr_addr),
        .i_wr_data (age_wr_data),
        .i_rd_addr (slot),
        .o_rd_data (age_rd_data)
    );

    // temperature in the upper half, humidity in the lower half
    amhr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .i_clk     (i_clk),
        .i_wr_en   (smp_we),
        .i_wr_addr (r_wp),
        .i_wr_data ({r_temp, r_hum}),
        .i_rd_addr (slot),
        .o_rd_data (smp_rd_data)
    );

    // period is held clamped to its legal range
    always_comb begin
        period_clamped = i_cfg_wr_data;
        if (i_cfg_wr_data < PERIOD_MIN) begin
            period_clamped = PERIOD_MIN;
        end else if (i_cfg_wr_data > PERIOD_MAX) begin
            period_clamped = PERIOD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_older     <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RESET;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_k         <= n_k;
            r_older     <= n_older;
            r_wb_valid  <= n_wb_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_period <= period_clamped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp    <= n_temp;
        r_hum     <= n_hum;
        r_found   <= n_found;
        r_wb_addr <= n_wb_addr;
        r_o_found <= n_o_found;
        r_o_age   <= n_o_age;
        r_o_temp  <= n_o_temp;
        r_o_hum   <= n_o_hum;
        r_o_count <= n_o_count;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_count     = r_count;
        n_k         = r_k;
        n_older     = r_older;
        n_wb_valid  = 1'b0;
        n_wb_addr   = r_wb_addr;
        n_temp      = r_temp;
        n_hum       = r_hum;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_found   = r_o_found;
        n_o_age     = r_o_age;
        n_o_temp    = r_o_temp;
        n_o_hum     = r_o_hum;
        n_o_count   = r_o_count;
        o_in_ready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    case (i_kind)
                        KIND_ADD: begin
                            n_temp = i_temperature;
                            n_hum  = i_humidity;
                            n_k    = '0;
                            // a full ring bumps every record but the one overwritten
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_older = ADDR_W'(DEPTH - 1);
                            end else begin
                                n_older = r_count[ADDR_W-1:0];
                            end
                            n_state = ST_WALK;
                        end
                        KIND_READ: begin
                            n_k     = ADDR_W'(i_read_index);
                            n_found = (CNT_W'(i_read_index) < r_count);
                            n_state = ST_RD_ISSUE;
                        end
                        KIND_CLEAR: begin
                            n_wp    = '0;
                            n_count = '0;
                        end
                        default: begin
                            // unused code, dropped
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // read age at slot(k) now, write it back bumped next cycle
                if (r_k != r_older) begin
                    n_wb_valid = 1'b1;
                    n_wb_addr  = slot;
                    n_k        = r_k + ADDR_W'(1);
                end else begin
                    n_state = ST_WALK_END;
                end
            end
            ST_WALK_END: begin
                // spare state, the last write-back landed in the final walk cycle
                n_state = ST_ADD_WRITE;
            end
            ST_ADD_WRITE: begin
                n_wp = r_wp + ADDR_W'(1);
                if (r_count != CNT_W'(DEPTH)) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_IDLE;
            end
            ST_RD_ISSUE: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                // address held, so ram data stays valid while the output is full
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_age     = r_found ? age_rd_data : 16'd0;
                    n_o_temp    = r_found ? smp_rd_data[31:16] : 16'd0;
                    n_o_hum     = r_found ? smp_rd_data[15:0] : 16'd0;
                    n_o_count   = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid          = r_out_valid;
    assign o_found              = r_o_found;
    assign o_age                = r_o_age;
    assign o_stored_temperature = r_o_temp;
    assign o_stored_humidity    = r_o_hum;
    assign o_record_count       = r_o_count;

endmodule

// ===== rtl/core/amhr_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependencies
module amhr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/sv/aging_measurement_history_ring_top_tb.sv =====
// self-checking testbench for aging_measurement_history_ring_top
// directed table then random traffic, each read result checked against a typed expectation or an in-bench ring model
// depends on amhr_pkg and the top level rtl
module aging_measurement_history_ring_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import amhr_pkg::*;

    // kind code the block must ignore
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // worst add bumps every age but the overwritten one, so this wait covers any item in flight
    localparam int IDLE_LATENCY = DEPTH + 44;
    localparam int SEGMENT_ITEMS = 362;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic                    found;
        logic [15:0]             age;
        logic signed [15:0]      temperature;
        logic signed [15:0]      humidity;
        logic [CNT_W-1:0]        count;
    } t_history_read;

    typedef struct packed {
        logic [1:0]              kind;
        logic [15:0]             temperature;
        logic [15:0]             humidity;
        logic [7:0]              read_index;
        logic                    typed;      // use want as typed below instead of the model
        t_history_read           want;
    } t_history_row;

    // dut connections, all inputs driven to known values from time zero
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [7:0]              i_cfg_wr_data = 8'd0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_kind = KIND_ADD;
    logic signed [15:0]      i_temperature = 16'sd0;
    logic signed [15:0]      i_humidity = 16'sd0;
    logic [7:0]              i_read_index = 8'd0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_found;
    logic [15:0]             o_age;
    logic signed [15:0]      o_stored_temperature;
    logic signed [15:0]      o_stored_humidity;
    logic [8:0]              o_record_count;

    // ring model state, mirrors what the block should hold
    logic [15:0]             ring_temp [DEPTH];
    logic [15:0]             ring_hum [DEPTH];
    logic [15:0]             ring_age [DEPTH];
    logic [ADDR_W-1:0]       ring_wr_ptr = '0;
    logic [CNT_W-1:0]        ring_count = '0;
    logic [7:0]              ring_period = PERIOD_RESET;

    t_history_read           pending_reads [$];
    t_history_row            directed_rows [$];
    int                      mismatches = 0;
    int unsigned             cycle_count = 0;
    int                      send_idle_pct = 13;
    int                      recv_idle_pct = 59;

    aging_measurement_history_ring_top i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_kind               (i_kind),
        .i_temperature        (i_temperature),
        .i_humidity           (i_humidity),
        .i_read_index         (i_read_index),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_found              (o_found),
        .o_age                (o_age),
        .o_stored_temperature (o_stored_temperature),
        .o_stored_humidity    (o_stored_humidity),
        .o_record_count       (o_record_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aging_measurement_history_ring_top_tb: errors");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // out of range period values are clamped into the legal window
    function automatic logic [7:0] held_period(input logic [7:0] value);
        if (value < PERIOD_MIN)
            return PERIOD_MIN;
        if (value > PERIOD_MAX)
            return PERIOD_MAX;
        return value;
    endfunction

    function automatic t_history_read read_result(input logic found, input logic [15:0] age,
                                                  input logic [15:0] t, input logic [15:0] h,
                                                  input logic [CNT_W-1:0] count);
        t_history_read r;
        r.found       = found;
        r.age         = age;
        r.temperature = t;
        r.humidity    = h;
        r.count       = count;
        return r;
    endfunction

    // advance the ring model by one accepted transfer; only a read yields a result
    task automatic apply_to_ring(input logic [1:0] kind, input logic [15:0] t,
                                 input logic [15:0] h, input logic [7:0] idx,
                                 output bit produced, output t_history_read res);
        int older;
        logic [ADDR_W-1:0] slot;
        produced = 1'b0;
        res = '0;
        case (kind)
            KIND_ADD: begin
                // every held record except the one about to be overwritten gets older
                older = (ring_count > DEPTH - 1) ? DEPTH - 1 : ring_count;
                for (int k = 0; k < older; k++) begin
                    slot = ADDR_W'((ring_wr_ptr + DEPTH - 1 - k) % DEPTH);
                    ring_age[slot] = ring_age[slot] + {8'd0, ring_period};
                end
                ring_temp[ring_wr_ptr] = t;
                ring_hum[ring_wr_ptr] = h;
                ring_age[ring_wr_ptr] = 16'd0;
                ring_wr_ptr = ring_wr_ptr + 1'b1;
                if (ring_count < DEPTH)
                    ring_count = ring_count + 1'b1;
            end
            KIND_READ: begin
                produced = 1'b1;
                res.count = ring_count;
                if (idx < ring_count) begin
                    slot = ADDR_W'((ring_wr_ptr + DEPTH - 1 - idx) % DEPTH);
                    res.found       = 1'b1;
                    res.age         = ring_age[slot];
                    res.temperature = ring_temp[slot];
                    res.humidity    = ring_hum[slot];
                end
            end
            KIND_CLEAR: begin
                ring_wr_ptr = '0;
                ring_count = '0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic push_row(input logic [1:0] kind, input logic [15:0] t, input logic [15:0] h,
                            input logic [7:0] idx, input logic typed, input t_history_read want);
        t_history_row row;
        row.kind        = kind;
        row.temperature = t;
        row.humidity    = h;
        row.read_index  = idx;
        row.typed       = typed;
        row.want        = want;
        directed_rows.push_back(row);
    endtask

    // one input transfer; entered and left at a falling edge
    task automatic send_item(input t_history_row row, input bit drain_first);
        bit produced;
        t_history_read res;
        if (drain_first) begin
            // hold off until every outstanding read has come back
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (pending_reads.size() != 0);
        end else begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid    <= 1'b1;
        i_kind        <= row.kind;
        i_temperature <= row.temperature;
        i_humidity    <= row.humidity;
        i_read_index  <= row.read_index;
        do @(posedge i_clk); while (!o_in_ready);
        apply_to_ring(row.kind, row.temperature, row.humidity, row.read_index, produced, res);
        if (produced)
            pending_reads.push_back(row.typed ? row.want : res);
        @(negedge i_clk);
    endtask

    // period writes only happen with the block idle
    task automatic write_period(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        // an add makes no result, so give any walk in progress time to finish
        repeat (IDLE_LATENCY) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ring_period = held_period(value);
    endtask

    // mostly adds and reads, reads mostly inside the held range; clears favored once full
    task automatic pick_random_row(output t_history_row row);
        int roll;
        row = '0;
        roll = $urandom_range(0, 999);
        row.temperature = 16'($urandom);
        row.humidity    = 16'($urandom);
        row.read_index  = 8'($urandom);
        if (roll >= 985) begin
            row.kind = KIND_SPARE;
        end else if (roll < 2 || (ring_count == DEPTH && roll < 15)) begin
            row.kind = KIND_CLEAR;
        end else if (roll < 590) begin
            row.kind = KIND_ADD;
        end else begin
            row.kind = KIND_READ;
            if (ring_count != 0 && $urandom_range(0, 3) != 0)
                row.read_index = 8'($urandom_range(0, ring_count - 1));
        end
    endtask

    // result checker: every read transfer against the oldest outstanding expectation
    always @(posedge i_clk) begin : result_check
        t_history_read want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                $error("read result with no read outstanding");
                mismatches++;
            end else begin
                want = pending_reads.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    mismatches++;
                end
                if (o_age !== want.age) begin
                    $error("age: expected %0d, got %0d", want.age, o_age);
                    mismatches++;
                end
                if (o_stored_temperature !== want.temperature) begin
                    $error("stored_temperature: expected %0d, got %0d",
                           $signed(want.temperature), o_stored_temperature);
                    mismatches++;
                end
                if (o_stored_humidity !== want.humidity) begin
                    $error("stored_humidity: expected %0d, got %0d",
                           $signed(want.humidity), o_stored_humidity);
                    mismatches++;
                end
                if (o_record_count !== want.count) begin
                    $error("record_count: expected %0d, got %0d", want.count, o_record_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        t_history_row row;
        logic [7:0] period_steps [4];
        int sent;

        // directed table, period at its reset value of 1
        // empty ring: nothing found, count zero
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd0, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd0));
        push_row(KIND_READ, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd0));
        // unused kind with every field bit set
        push_row(KIND_SPARE, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, '0);
        // field extremes
        push_row(KIND_ADD, 16'h7FFF, 16'h8000, 8'd0, 1'b0, '0);
        push_row(KIND_ADD, 16'h8000, 16'h7FFF, 8'd0, 1'b0, '0);
        push_row(KIND_ADD, 16'h0000, 16'hFFFF, 8'd0, 1'b0, '0);
        push_row(KIND_ADD, 16'hFFFF, 16'h0000, 8'd0, 1'b0, '0);
        // newest is age zero, oldest has aged three adds at period 1
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd0, 1'b1,
                 read_result(1'b1, 16'd0, 16'hFFFF, 16'h0000, 9'd4));
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd3, 1'b1,
                 read_result(1'b1, 16'd3, 16'h7FFF, 16'h8000, 9'd4));
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd2, 1'b0, '0);
        // index equal to the count and the top index are both misses
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd4, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd4));
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd255, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd4));
        push_row(KIND_SPARE, 16'h1234, 16'h5678, 8'h5A, 1'b0, '0);
        // clear empties the ring
        push_row(KIND_CLEAR, 16'h0000, 16'h0000, 8'd0, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd0, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd0));
        push_row(KIND_ADD, 16'h5555, 16'hAAAA, 8'd0, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd0, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd1, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd1));
        // clear twice, the second on an already empty ring
        push_row(KIND_CLEAR, 16'h0000, 16'h0000, 8'd0, 1'b0, '0);
        push_row(KIND_CLEAR, 16'h0000, 16'h0000, 8'd0, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd0, 1'b1,
                 read_result(1'b0, 16'd0, 16'd0, 16'd0, 9'd0));
        push_row(KIND_ADD, 16'h0001, 16'h0001, 8'd0, 1'b0, '0);
        push_row(KIND_ADD, 16'h0002, 16'h0002, 8'd0, 1'b0, '0);
        push_row(KIND_READ, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);

        // all-ones clamps to the max, zero clamps to the min
        period_steps[0] = 8'hFF;
        period_steps[1] = 8'h00;
        period_steps[2] = 8'd200;
        period_steps[3] = PERIOD_MAX;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n])
            send_item(directed_rows[n], 1'b0);

        // random segments: sender light / receiver heavy, then swapped, then no idling
        for (int seg = 0; seg < 4; seg++) begin
            case (seg)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_period(period_steps[seg]);
            sent = 0;
            while (sent < SEGMENT_ITEMS) begin
                pick_random_row(row);
                send_item(row, $urandom_range(0, 119) == 0);
                // ignored kinds do not count as traffic
                if (row.kind != KIND_SPARE)
                    sent++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (IDLE_LATENCY) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("aging_measurement_history_ring_top_tb: clean");
        end else begin
            $display("aging_measurement_history_ring_top_tb: errors");
        end
        $finish;
    end

endmodule
